// ===== sv/stwm_pkg.sv =====
package stwm_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int DEPTH_DEF    = 128;

    localparam int STAMP_W = 64;
    localparam int CFG_W   = 40;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_LAG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE     = 2'd2;

    localparam logic [CFG_W-1:0] WINDOW_RST    = 40'd1000000000;
    localparam logic [CFG_W-1:0] CROSS_LAG_RST = 40'd1000000000;
    localparam logic [CFG_W-1:0] STALE_RST     = 40'd5000000000;

    // 1e6 s in ns
    localparam logic [STAMP_W-1:0] MAX_GAP_NS = 64'd1000000000000000;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NULL  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;
    localparam logic [1:0] ST_LAG   = 2'd3;

    typedef struct packed {
        logic [2:0]         channel;
        logic [STAMP_W-1:0] stamp_ns;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] window_count;
        logic       window_full;
        logic       stale_seen;
    } t_out_item;

    typedef struct packed {
        logic gt;      // a > b
        logic exceed;  // a > b and a - b > limit
    } t_cmp_res;

endpackage

// ===== sv/stwm_cmp_unit.sv =====
module stwm_cmp_unit (
    input  logic [stwm_pkg::STAMP_W-1:0] i_a,
    input  logic [stwm_pkg::STAMP_W-1:0] i_b,
    input  logic [stwm_pkg::STAMP_W-1:0] i_limit,
    output stwm_pkg::t_cmp_res           o_res
);

    logic [stwm_pkg::STAMP_W:0] diff;

    assign diff = {1'b0, i_a} - {1'b0, i_b};

    always_comb begin
        o_res.gt     = !diff[stwm_pkg::STAMP_W] && (diff[stwm_pkg::STAMP_W-1:0] != '0);
        o_res.exceed = o_res.gt && (diff[stwm_pkg::STAMP_W-1:0] > i_limit);
    end

endmodule

// ===== sv/sensor_timestamp_window_monitor.sv =====
// states: a null stamp or an empty channel goes CHECK, DONE; a stamp rejected on order
// or gap goes CHECK, LAST, DONE; a stored stamp goes CHECK, LAST, TRIM, a walk over the
// channels (RDK, CMPA, CMPB per other non-empty one, RDK alone per skipped one), DONE;
// the walk shares one subtract/compare unit; one transaction at a time, the next accept
// follows the result load; a stalled result holds the block until it is taken
// reset: synchronous active low, clears pointers, counts, full flags, loads default limits
module sensor_timestamp_window_monitor #(
    parameter int CHANNELS = stwm_pkg::CHANNELS_DEF,
    parameter int DEPTH    = stwm_pkg::DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  stwm_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output stwm_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_wr_en,
    input  logic [stwm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stwm_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CW  = $clog2(CHANNELS);
    localparam int CHW = (CW > 3) ? CW : 3;
    localparam int PW  = $clog2(DEPTH);
    localparam int NW  = $clog2(DEPTH + 1);
    localparam int AW  = $clog2(CHANNELS * DEPTH);
    localparam int SW  = stwm_pkg::STAMP_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_TRIM  = 3'd3;
    localparam logic [2:0] S_RDK   = 3'd4;
    localparam logic [2:0] S_CMPA  = 3'd5;
    localparam logic [2:0] S_CMPB  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        ptr_dec = (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
    endfunction

    logic [2:0]     r_state, n_state;
    logic [CHW-1:0] r_ch;
    logic [SW-1:0]  r_t;
    logic [CW-1:0]  r_k, n_k;
    logic [1:0]     r_status, n_status;
    logic           r_stale, n_stale;

    logic [stwm_pkg::CFG_W-1:0] r_window, r_cross_lag, r_stale_lim;

    logic [PW-1:0] r_head  [CHANNELS];
    logic [PW-1:0] r_tail  [CHANNELS];
    logic [NW-1:0] r_count [CHANNELS];
    logic          r_full  [CHANNELS];

    logic [SW-1:0] mem [CHANNELS*DEPTH];
    logic [SW-1:0] r_rd_data;

    logic                r_out_valid;
    stwm_pkg::t_out_item r_out_data;

    logic          ch_ok;
    logic [CW-1:0] ch_idx;
    logic [CW-1:0] p;
    logic [AW-1:0] base_p;
    logic [PW-1:0] head_p, tail_p;
    logic [NW-1:0] count_p;
    logic          at_depth;

    logic          mem_we, mem_re;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          head_inc, tail_inc, cnt_inc, cnt_dec, full_set;
    logic          out_load;

    logic [SW-1:0]      cmp_a, cmp_b, cmp_lim;
    stwm_pkg::t_cmp_res cmp_res;

    stwm_cmp_unit u_cmp (
        .i_a     (cmp_a),
        .i_b     (cmp_b),
        .i_limit (cmp_lim),
        .o_res   (cmp_res)
    );

    assign ch_ok  = {1'b0, r_ch} < (CHW + 1)'(CHANNELS);
    assign ch_idx = r_ch[CW-1:0];

    // the walk reads other channels, every other state works on the item's channel
    assign p        = (r_state == S_RDK) ? r_k : ch_idx;
    assign base_p   = AW'(p) * AW'(DEPTH);
    assign head_p   = r_head[p];
    assign tail_p   = r_tail[p];
    assign count_p  = r_count[p];
    assign at_depth = (count_p == NW'(DEPTH));

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign wr_addr     = base_p + AW'(tail_p);

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_status = r_status;
        n_stale  = r_stale;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        rd_addr  = base_p + AW'(ptr_dec(tail_p));
        head_inc = 1'b0;
        tail_inc = 1'b0;
        cnt_inc  = 1'b0;
        cnt_dec  = 1'b0;
        full_set = 1'b0;
        cmp_a    = r_t;
        cmp_b    = r_rd_data;
        cmp_lim  = stwm_pkg::MAX_GAP_NS;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state  = S_CHECK;
                    n_status = stwm_pkg::ST_OK;
                    n_stale  = 1'b0;
                end
            end
            S_CHECK: begin
                if (!ch_ok || r_t == '0 || r_t == '1) begin
                    n_status = stwm_pkg::ST_NULL;
                    n_state  = S_DONE;
                end else if (count_p == '0) begin
                    mem_we   = 1'b1;
                    tail_inc = 1'b1;
                    cnt_inc  = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (!cmp_res.gt || cmp_res.exceed) begin
                    n_status = stwm_pkg::ST_ORDER;
                    n_state  = S_DONE;
                end else begin
                    // make room at depth, push, and fetch the oldest entry
                    mem_we   = 1'b1;
                    tail_inc = 1'b1;
                    head_inc = at_depth;
                    cnt_inc  = !at_depth;
                    mem_re   = 1'b1;
                    rd_addr  = base_p + AW'(at_depth ? ptr_inc(head_p) : head_p);
                    n_state  = S_TRIM;
                end
            end
            S_TRIM: begin
                cmp_lim = SW'(r_window);
                if (cmp_res.exceed) begin
                    head_inc = 1'b1;
                    cnt_dec  = 1'b1;
                    full_set = 1'b1;
                end
                n_k     = '0;
                n_state = S_RDK;
            end
            S_RDK: begin
                if (r_k == ch_idx || count_p == '0) begin
                    if (r_k == CW'(CHANNELS - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_CMPA;
                end
            end
            S_CMPA: begin
                // other channel ahead
                cmp_a   = r_rd_data;
                cmp_b   = r_t;
                cmp_lim = SW'(r_cross_lag);
                if (cmp_res.exceed) begin
                    n_status = stwm_pkg::ST_LAG;
                end
                n_state = S_CMPB;
            end
            S_CMPB: begin
                // other channel behind
                cmp_lim = SW'(r_stale_lim);
                if (cmp_res.exceed) begin
                    n_stale = 1'b1;
                end
                if (r_k == CW'(CHANNELS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_RDK;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_status    <= stwm_pkg::ST_OK;
            r_stale     <= 1'b0;
            r_out_valid <= 1'b0;
            r_window    <= stwm_pkg::WINDOW_RST;
            r_cross_lag <= stwm_pkg::CROSS_LAG_RST;
            r_stale_lim <= stwm_pkg::STALE_RST;
            for (int i = 0; i < CHANNELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
                r_full[i]  <= 1'b0;
            end
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_status <= n_status;
            r_stale  <= n_stale;

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    stwm_pkg::CFG_WINDOW:    r_window    <= i_cfg_data;
                    stwm_pkg::CFG_CROSS_LAG: r_cross_lag <= i_cfg_data;
                    stwm_pkg::CFG_STALE:     r_stale_lim <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (head_inc) begin
                r_head[p] <= ptr_inc(head_p);
            end
            if (tail_inc) begin
                r_tail[p] <= ptr_inc(tail_p);
            end
            if (cnt_inc) begin
                r_count[p] <= count_p + 1'b1;
            end else if (cnt_dec) begin
                r_count[p] <= count_p - 1'b1;
            end
            if (full_set) begin
                r_full[p] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_ch <= CHW'(i_in_data.channel);
            r_t  <= i_in_data.stamp_ns;
        end
        if (out_load) begin
            r_out_data.status       <= r_status;
            r_out_data.window_count <= ch_ok ? 8'(count_p) : 8'd0;
            r_out_data.window_full  <= ch_ok && r_full[p];
            r_out_data.stale_seen   <= r_stale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= r_t;
        end
        if (mem_re) begin
            r_rd_data <= mem[rd_addr];
        end
    end

endmodule
